### rtl/rn_pkg.sv
// Shared constants and types for the ratio normalizer.
`timescale 1ns / 1ps

package rn_pkg;

   // Default fixnum width
   localparam int unsigned FIX_WIDTH_DEF = 32;

   // Divider status seen by the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_EUCLID = 5'b00010,
      ST_DIV_DE = 5'b00100,
      ST_DIV_NU = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

endpackage

### rtl/ratio_normalizer.sv
// Zero numerator and most-negative over minus one skip every divide; a gcd of 1 skips the final two.
// One request at a time; a single shared one-bit-per-cycle divider serves Euclid and both final divides.
// req_ready is high only while idle; a finished result waits in the rsp register.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp_valid.
`timescale 1ns / 1ps

module ratio_normalizer #(
   parameter int unsigned FIX_WIDTH = rn_pkg::FIX_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [FIX_WIDTH-1:0] req_numer_in,
   input  logic signed [FIX_WIDTH-1:0] req_denom_in,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_is_ratio,
   output logic signed [FIX_WIDTH:0]   rsp_numer_out,
   output logic        [FIX_WIDTH-1:0] rsp_denom_out,
   output logic                        rsp_numer_wide,
   output logic                        rsp_denom_wide
);

   localparam logic [FIX_WIDTH-1:0] TOP = {1'b1, {(FIX_WIDTH-1){1'b0}}};
   localparam logic [FIX_WIDTH-1:0] ONE = FIX_WIDTH'(1);

   rn_pkg::state_type    state_ff, state_in;
   rn_pkg::div_stat_type div_stat;

   logic [FIX_WIDTH-1:0] nu_ff, nu_in;
   logic [FIX_WIDTH-1:0] de_ff, de_in;
   logic [FIX_WIDTH-1:0] n_ff, n_in;
   logic                 neg_ff, neg_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 is_ratio_ff, is_ratio_in;
   logic [FIX_WIDTH:0]   numer_ff, numer_in;
   logic [FIX_WIDTH-1:0] denom_ff, denom_in;
   logic                 nwide_ff, nwide_in;
   logic                 dwide_ff, dwide_in;

   logic                 div_start;
   logic [FIX_WIDTH-1:0] div_dividend, div_divisor, div_quo, div_rem;

   logic [FIX_WIDTH-1:0] nv, dv, nu_mag, de_mag;
   logic                 nneg, dneg, accept;

   assign nv     = req_numer_in;
   assign dv     = req_denom_in;
   assign nneg   = nv[FIX_WIDTH-1];
   assign dneg   = dv[FIX_WIDTH-1];
   assign nu_mag = nneg ? (~nv + ONE) : nv;
   assign de_mag = dneg ? (~dv + ONE) : dv;

   assign req_ready = (state_ff == rn_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   rn_div #(.WIDTH(FIX_WIDTH)) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .stat      (div_stat),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Sequencer: special cases go straight to finish; else Euclid loop, then both parts divided by a gcd above 1
   always_comb begin
      state_in     = state_ff;
      nu_in        = nu_ff;
      de_in        = de_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      div_start    = 1'b0;
      div_dividend = de_mag;
      div_divisor  = nu_mag;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      is_ratio_in  = is_ratio_ff;
      numer_in     = numer_ff;
      denom_in     = denom_ff;
      nwide_in     = nwide_ff;
      dwide_in     = dwide_ff;
      unique case (state_ff)
         rn_pkg::ST_IDLE: begin
            if (accept) begin
               priority if (nv == '0) begin
                  // zero numerator: integer zero
                  nu_in    = '0;
                  de_in    = ONE;
                  neg_in   = 1'b0;
                  state_in = rn_pkg::ST_FINISH;
               end else if (dneg && (&dv) && nv == TOP) begin
                  // most negative over minus one
                  nu_in    = TOP;
                  de_in    = ONE;
                  neg_in   = 1'b0;
                  state_in = rn_pkg::ST_FINISH;
               end else begin
                  nu_in     = nu_mag;
                  de_in     = de_mag;
                  n_in      = nu_mag;
                  neg_in    = dneg ? !nneg : nneg;
                  div_start = 1'b1;
                  state_in  = rn_pkg::ST_EUCLID;
               end
            end
         end
         rn_pkg::ST_EUCLID: begin
            if (div_stat.done) begin
               if (div_rem == '0) begin
                  if (n_ff == ONE) begin
                     state_in = rn_pkg::ST_FINISH;
                  end else begin
                     div_start    = 1'b1;
                     div_dividend = de_ff;
                     div_divisor  = n_ff;
                     state_in     = rn_pkg::ST_DIV_DE;
                  end
               end else begin
                  div_start    = 1'b1;
                  div_dividend = n_ff;
                  div_divisor  = div_rem;
                  n_in         = div_rem;
               end
            end
         end
         rn_pkg::ST_DIV_DE: begin
            if (div_stat.done) begin
               de_in        = div_quo;
               div_start    = 1'b1;
               div_dividend = nu_ff;
               div_divisor  = n_ff;
               state_in     = rn_pkg::ST_DIV_NU;
            end
         end
         rn_pkg::ST_DIV_NU: begin
            if (div_stat.done) begin
               nu_in    = div_quo;
               state_in = rn_pkg::ST_FINISH;
            end
         end
         rn_pkg::ST_FINISH: begin
            // load the response once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               is_ratio_in  = (de_ff != ONE);
               numer_in     = neg_ff ? (~{1'b0, nu_ff} + (FIX_WIDTH+1)'(1))
                                     : {1'b0, nu_ff};
               denom_in     = de_ff;
               nwide_in     = !neg_ff && (nu_ff == TOP);
               dwide_in     = (de_ff == TOP);
               state_in     = rn_pkg::ST_IDLE;
            end
         end
         default: state_in = rn_pkg::ST_IDLE;
      endcase
   end

   // Working registers and response payload
   always_ff @(posedge clock) begin
      nu_ff       <= nu_in;
      de_ff       <= de_in;
      n_ff        <= n_in;
      neg_ff      <= neg_in;
      is_ratio_ff <= is_ratio_in;
      numer_ff    <= numer_in;
      denom_ff    <= denom_in;
      nwide_ff    <= nwide_in;
      dwide_ff    <= dwide_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rn_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_ratio   = is_ratio_ff;
   assign rsp_numer_out  = numer_ff;
   assign rsp_denom_out  = denom_ff;
   assign rsp_numer_wide = nwide_ff;
   assign rsp_denom_wide = dwide_ff;

   // Integer results always carry a unit denominator
   a_int_denom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !is_ratio_ff |-> denom_ff == ONE)
      else $error("integer response without unit denominator");

   // A wide denominator can only come with a true ratio
   a_dwide_ratio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && dwide_ff |-> is_ratio_ff)
      else $error("wide denominator on integer response");

   // Divider completions only arrive while a divide is expected
   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == rn_pkg::ST_EUCLID || state_ff == rn_pkg::ST_DIV_DE
                         || state_ff == rn_pkg::ST_DIV_NU))
      else $error("divider done outside a divide state");

endmodule

### rtl/rn_div.sv
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module rn_div #(
   parameter int unsigned WIDTH = rn_pkg::FIX_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [WIDTH-1:0]         dividend,
   input  logic [WIDTH-1:0]         divisor,
   output rn_pkg::div_stat_type     stat,
   output logic [WIDTH-1:0]         quotient,
   output logic [WIDTH-1:0]         remainder
);

   localparam int unsigned CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [WIDTH:0]   rem_shift;
   logic [WIDTH+1:0] diff;
   logic             borrow;

   // One trial subtraction per cycle
   assign rem_shift = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign borrow    = diff[WIDTH+1];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = borrow ? rem_shift : diff[WIDTH:0];
         quo_in = {quo_ff[WIDTH-2:0], ~borrow};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Datapath, no reset needed
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[WIDTH-1:0];

   // A new divide only starts on an idle unit
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");

   // Done pulses only as the unit goes idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

   // A start always makes the unit busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

endmodule

### tb/sv/testbench.sv
// Self-checking bench for the ratio normalizer: predicts each reduced fraction and checks it.
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned W = rn_pkg::FIX_WIDTH_DEF;
   localparam logic [W-1:0] MIN_FIX   = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MAX_FIX   = ~MIN_FIX;
   localparam logic [W-1:0] NEG_ONE   = '1;
   localparam logic [W-1:0] MIN_PLUS1 = MIN_FIX + 1'b1;
   localparam int DRAIN_CYCLES   = 1700;
   localparam int HOLD_CYCLES    = 4000;
   localparam int PHASE_ITEMS    = 370;
   localparam int unsigned TIMEOUT_CYCLES = 20_000_000;

   // one reduced fraction as the block reports it
   typedef struct packed {
      logic         is_ratio;
      logic [W:0]   numer;
      logic [W-1:0] denom;
      logic         numer_wide;
      logic         denom_wide;
   } fraction_type;

   // directed requests: {numerator, denominator}
   localparam logic [2*W-1:0] DIRECTED [25] = '{
      {32'd0, 32'd5}, {32'd0, 32'd0}, {MIN_FIX, NEG_ONE}, {MIN_FIX, 32'd1},
      {MIN_FIX, MIN_FIX}, {32'd1, MIN_FIX}, {NEG_ONE, MIN_FIX}, {MAX_FIX, MIN_FIX},
      {MIN_FIX, MAX_FIX}, {MAX_FIX, MAX_FIX}, {32'd6, 32'(-4)}, {32'(-6), 32'd4},
      {32'(-6), 32'(-4)}, {32'd7, 32'd0}, {32'(-7), 32'd0}, {32'd5, 32'd1},
      {32'd10, 32'(-5)}, {MIN_FIX, 32'd2}, {32'd2, MIN_FIX}, {MAX_FIX, NEG_ONE},
      {NEG_ONE, NEG_ONE}, {MIN_PLUS1, NEG_ONE}, {MIN_FIX, 32'(-2)},
      {32'd1836311903, 32'd1134903170}, {32'(-1134903170), 32'd1836311903}
   };

   // Holds the expected reduced fractions in request order
   class lowest_terms_board;
      fraction_type pending[$];
      int errors;
      int noted;
      int checked;
      int ratios;

      function new();
         errors = 0;
         noted = 0;
         checked = 0;
         ratios = 0;
      endfunction

      // reduce n/d by Euclid's gcd; sign goes on the numerator
      function fraction_type reduce_fraction(logic [W-1:0] n, logic [W-1:0] d);
         fraction_type res;
         logic [63:0] top, nu, de, m, g, r, signed_nu;
         logic nneg, dneg, negative;
         res = '{is_ratio: 1'b0, numer: '0, denom: 1, numer_wide: 1'b0, denom_wide: 1'b0};
         top = 64'd1 << (W - 1);
         if (n == '0)
            return res;
         nneg = n[W-1];
         dneg = d[W-1];
         // most negative over minus one overflows to +2^(W-1)
         if (d == NEG_ONE && n == MIN_FIX) begin
            res.numer = top[W:0];
            res.numer_wide = 1'b1;
            return res;
         end
         negative = dneg ? !nneg : nneg;
         nu = 64'(n);
         de = 64'(d);
         if (nneg)
            nu = (64'd0 - nu) & {32'd0, {W{1'b1}}};
         if (dneg)
            de = (64'd0 - de) & {32'd0, {W{1'b1}}};
         // zero denominator falls out with g = |n|
         m = de;
         g = nu;
         r = m % g;
         while (r != 0) begin
            m = g;
            g = r;
            r = m % g;
         end
         if (g != 1) begin
            de = de / g;
            nu = nu / g;
         end
         signed_nu = negative ? 64'd0 - nu : nu;
         res.is_ratio = (de != 1);
         res.numer = signed_nu[W:0];
         res.denom = de[W-1:0];
         res.numer_wide = !negative && nu == top;
         res.denom_wide = de == top;
         return res;
      endfunction

      function void note_request(logic [W-1:0] n, logic [W-1:0] d);
         pending.push_back(reduce_fraction(n, d));
         noted++;
      endfunction

      function void check_response(fraction_type got);
         fraction_type want;
         if (pending.size() == 0) begin
            $error("response with nothing expected: numer_out %0d denom_out %0d",
                   $signed(got.numer), got.denom);
            errors++;
            return;
         end
         want = pending.pop_front();
         checked++;
         if (want.is_ratio)
            ratios++;
         if (got.is_ratio !== want.is_ratio) begin
            $error("is_ratio: expected %0d, actual %0d", want.is_ratio, got.is_ratio);
            errors++;
         end
         if (got.numer !== want.numer) begin
            $error("numer_out: expected %0d, actual %0d", $signed(want.numer), $signed(got.numer));
            errors++;
         end
         if (got.denom !== want.denom) begin
            $error("denom_out: expected %0d, actual %0d", want.denom, got.denom);
            errors++;
         end
         if (got.numer_wide !== want.numer_wide) begin
            $error("numer_wide: expected %0d, actual %0d", want.numer_wide, got.numer_wide);
            errors++;
         end
         if (got.denom_wide !== want.denom_wide) begin
            $error("denom_wide: expected %0d, actual %0d", want.denom_wide, got.denom_wide);
            errors++;
         end
      endfunction

      function int outstanding();
         return pending.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [W-1:0] req_numer_in;
   logic [W-1:0] req_denom_in;
   logic rsp_valid;
   logic rsp_ready;
   logic rsp_is_ratio;
   logic [W:0] rsp_numer_out;
   logic [W-1:0] rsp_denom_out;
   logic rsp_numer_wide;
   logic rsp_denom_wide;

   lowest_terms_board board;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_goal = 0;
   int hold_seen = 0;
   int unsigned cycle_count = 0;

   ratio_normalizer #(.FIX_WIDTH(W)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_numer_in(req_numer_in),
      .req_denom_in(req_denom_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_is_ratio(rsp_is_ratio),
      .rsp_numer_out(rsp_numer_out),
      .rsp_denom_out(rsp_denom_out),
      .rsp_numer_wide(rsp_numer_wide),
      .rsp_denom_wide(rsp_denom_wide)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == TIMEOUT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response side: random stalls plus a long hold-off each time hold_goal is bumped
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_goal) begin
            hold_seen = hold_goal;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_response('{rsp_is_ratio, rsp_numer_out, rsp_denom_out,
                                rsp_numer_wide, rsp_denom_wide});
   end

   // offer one request; entered and left at a falling edge
   task automatic send_fraction(input logic [W-1:0] n, input logic [W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_numer_in <= n;
      req_denom_in <= d;
      do @(posedge clock); while (!req_ready);
      board.note_request(n, d);
      @(negedge clock);
   endtask

   // pause the request side until every response is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (board.outstanding() != 0)
         @(negedge clock);
   endtask

   function automatic logic [W-1:0] edge_value();
      case ($urandom_range(7))
         0: return '0;
         1: return 1;
         2: return NEG_ONE;
         3: return MIN_FIX;
         4: return MAX_FIX;
         5: return MIN_PLUS1;
         6: return W'($urandom_range(2, 9));
         default: return W'(1) << $urandom_range(W - 1);
      endcase
   endfunction

   // random fraction: full range, shared factors, small, edge values, powers of two
   task automatic pick_fraction(output logic [W-1:0] n, output logic [W-1:0] d);
      int roll;
      logic [W-1:0] g;
      roll = $urandom_range(99);
      if (roll < 40) begin
         n = $urandom;
         d = $urandom;
      end else if (roll < 65) begin
         g = $urandom_range(1, 40000);
         n = g * W'($urandom_range(1, 50000));
         d = g * W'($urandom_range(1, 50000));
         if ($urandom_range(1)) n = -n;
         if ($urandom_range(1)) d = -d;
      end else if (roll < 80) begin
         n = W'($urandom_range(128)) - 64;
         d = W'($urandom_range(128)) - 64;
      end else if (roll < 90) begin
         n = edge_value();
         d = edge_value();
      end else begin
         n = W'(1) << $urandom_range(W - 1);
         d = W'(1) << $urandom_range(W - 1);
         if ($urandom_range(1)) n = -n;
         if ($urandom_range(1)) d = -d;
      end
   endtask

   task automatic random_phase(input int idle_pct, input int stall_pct, input int count);
      logic [W-1:0] n, d;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         pick_fraction(n, d);
         send_fraction(n, d);
      end
      wait_for_results();
   endtask

   initial begin
      logic [W-1:0] n, d;
      reset = 1'b1;
      req_valid = 1'b0;
      req_numer_in = '0;
      req_denom_in = '0;
      board = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed corner cases, no idling
      foreach (DIRECTED[i])
         send_fraction(DIRECTED[i][2*W-1:W], DIRECTED[i][W-1:0]);
      wait_for_results();

      random_phase(0, 0, PHASE_ITEMS);

      // long response hold-off while requests keep coming
      hold_goal++;
      repeat (10) begin
         pick_fraction(n, d);
         send_fraction(n, d);
      end
      wait_for_results();

      random_phase(87, 0, PHASE_ITEMS);
      random_phase(0, 87, PHASE_ITEMS);
      random_phase(21, 21, PHASE_ITEMS);
      random_phase(0, 0, PHASE_ITEMS);

      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("Reduced %0d fractions (%0d true ratios) across directed corners, random mixes,",
               board.checked, board.ratios);
      $display("idle and stall phases and a long response hold-off; %0d requests sent.",
               board.noted);
      if (board.errors == 0 && board.outstanding() == 0) begin
         $display("TB_OK");
      end else begin
         if (board.outstanding() != 0)
            $error("%0d expected responses never arrived", board.outstanding());
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/rn_pkg.sv
rtl/rn_div.sv
rtl/ratio_normalizer.sv
tb/sv/testbench.sv
